// ===== hw/rtl/bct_pkg.sv =====
// ----------------------------------------------------------------------------
// bct_pkg
// Types and constants shared by the box collision test block.
// ----------------------------------------------------------------------------
`default_nettype none

package bct_pkg;

  localparam int COORD_W = 32;
  localparam int SIZE_W  = 31;
  localparam int DEPTH_W = 31;

  localparam int IN_TDATA_W  = 288;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_SIZE_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_SIZE_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_SIZE_Z  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GROUND_LEVEL = 2'd3;

  localparam logic [SIZE_W-1:0]  BOX_SIZE_RESET     = 31'd65536;
  localparam logic [COORD_W-1:0] GROUND_LEVEL_RESET = 32'd0;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 31'h7fff_ffff;

  typedef enum logic [1:0] {
    KIND_BOX    = 2'd0,
    KIND_GROUND = 2'd1
  } kind_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic               hit;
    axis_t              axis;
    logic               neg;
    logic [DEPTH_W-1:0] depth;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/box_collision_test_top.sv =====
// ----------------------------------------------------------------------------
// box_collision_test_top
// Box-vs-box overlap and box-vs-ground contact test, one request per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one test request per handshake. tuser carries the test kind
//           (box against box, box against ground, anything else misses).
//   out_* : one result per request, in request order.
//   cfg_* : register writes (own box extents, ground level); always ready,
//           to be written only while no request is in flight (user's duty).
// Pipeline: three register stages (input, product, result); a request moves
//   from input to product to result register, which drives out_tvalid.
// Throughput: one request per cycle while out_tready stays high. The ground
//   test needs three 31x32 multiplies, registered before the final sum and
//   compare, which sets the stage count.
// Reset: synchronous, active low; clears all stage valids and loads the
//   register reset values (unit extents, ground at zero).
// Stall: each stage holds while the one after it is full and stalled;
//   empty stages still take new requests, so in_tready drops only once
//   every stage holds a request.
// ----------------------------------------------------------------------------
`default_nettype none

module box_collision_test_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // configuration writes
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [bct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [bct_pkg::CFG_DATA_W-1:0]   cfg_data,
  // requests
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // center_x[31:0] center_y[63:32] center_z[95:64] arg_a[127:96]
  // arg_b[159:128] arg_c[191:160] other_size_x[222:192]
  // other_size_y[253:223] other_size_z[284:254] zero[287:285]
  input  wire  [bct_pkg::IN_TDATA_W-1:0]   in_tdata,
  // kind[1:0]
  input  wire  [bct_pkg::IN_TUSER_W-1:0]   in_tuser,
  // results
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // hit[0] normal_axis[2:1] normal_negative[3] penetration[34:4] zero[39:35]
  output logic [bct_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int PROD_W = 63;
  localparam int SUM_W  = 64;
  localparam int TW     = SUM_W - (FRAC_BITS + 1);
  localparam int VW     = TW + 2;

  // configuration
  logic [bct_pkg::SIZE_W-1:0]  own_size_r [3];
  logic [bct_pkg::COORD_W-1:0] ground_level_r;

  // stage 1: input register
  logic                        s1_valid_r;
  bct_pkg::kind_t              s1_kind_r;
  logic [bct_pkg::COORD_W-1:0] s1_center_r [3];
  logic [bct_pkg::COORD_W-1:0] s1_arg_r [3];
  logic [bct_pkg::SIZE_W-1:0]  s1_osize_r [3];

  // stage 2: products and box result
  logic                        s2_valid_r;
  bct_pkg::kind_t              s2_kind_r;
  bct_pkg::result_t            s2_box_r;
  logic [PROD_W-1:0]           s2_prod_r [3];
  logic [32:0]                 s2_gc_r;

  // stage 3: output register
  logic                        out_valid_r;
  bct_pkg::result_t            out_res_r;

  logic ready1, ready2, ready3;

  // stage A comb
  logic [32:0]                 d      [3];
  logic [32:0]                 ad     [3];
  logic [31:0]                 ssum   [3];
  logic [34:0]                 dbl    [3];
  logic [31:0]                 up_mag [3];
  logic [PROD_W-1:0]           prod   [3];
  logic [34:0]                 best;
  bct_pkg::axis_t              best_axis;
  logic                        best_neg;
  bct_pkg::result_t            box_res;
  logic [32:0]                 gc;

  // stage B comb
  logic [SUM_W-1:0]            gsum;
  logic [TW-1:0]               gt;
  logic                        rem_nz;
  logic [VW-1:0]               gv;
  bct_pkg::result_t            ground_res;
  bct_pkg::result_t            res_nxt;

  assign ready3    = !out_valid_r || out_tready;
  assign ready2    = !s2_valid_r || ready3;
  assign ready1    = !s1_valid_r || ready2;
  assign in_tready = ready1;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_size_r[0]  <= bct_pkg::BOX_SIZE_RESET;
      own_size_r[1]  <= bct_pkg::BOX_SIZE_RESET;
      own_size_r[2]  <= bct_pkg::BOX_SIZE_RESET;
      ground_level_r <= bct_pkg::GROUND_LEVEL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        bct_pkg::REG_BOX_SIZE_X:   own_size_r[0]  <= cfg_data[30:0];
        bct_pkg::REG_BOX_SIZE_Y:   own_size_r[1]  <= cfg_data[30:0];
        bct_pkg::REG_BOX_SIZE_Z:   own_size_r[2]  <= cfg_data[30:0];
        bct_pkg::REG_GROUND_LEVEL: ground_level_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (ready1) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_tvalid) begin
      s1_kind_r      <= bct_pkg::kind_t'(in_tuser);
      s1_center_r[0] <= in_tdata[31:0];
      s1_center_r[1] <= in_tdata[63:32];
      s1_center_r[2] <= in_tdata[95:64];
      s1_arg_r[0]    <= in_tdata[127:96];
      s1_arg_r[1]    <= in_tdata[159:128];
      s1_arg_r[2]    <= in_tdata[191:160];
      s1_osize_r[0]  <= in_tdata[222:192];
      s1_osize_r[1]  <= in_tdata[253:223];
      s1_osize_r[2]  <= in_tdata[284:254];
    end
  end

  // stage A: per-axis box terms and ground products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i]      = {s1_arg_r[i][31], s1_arg_r[i]} - {s1_center_r[i][31], s1_center_r[i]};
      ad[i]     = d[i][32] ? (~d[i] + 33'd1) : d[i];
      ssum[i]   = {1'b0, own_size_r[i]} + {1'b0, s1_osize_r[i]};
      // twice the overlap: own + other - 2|d|
      dbl[i]    = {3'b000, ssum[i]} - {1'b0, ad[i], 1'b0};
      up_mag[i] = s1_arg_r[i][31] ? (~s1_arg_r[i] + 32'd1) : s1_arg_r[i];
      prod[i]   = {32'd0, own_size_r[i]} * {31'd0, up_mag[i]};
    end
  end

  always_comb begin
    best      = dbl[0];
    best_axis = bct_pkg::AXIS_X;
    best_neg  = d[0][32] || (d[0] == 33'd0);
    if (dbl[1] < best) begin
      best      = dbl[1];
      best_axis = bct_pkg::AXIS_Y;
      best_neg  = d[1][32] || (d[1] == 33'd0);
    end
    if (dbl[2] < best) begin
      best      = dbl[2];
      best_axis = bct_pkg::AXIS_Z;
      best_neg  = d[2][32] || (d[2] == 33'd0);
    end
    if (dbl[0][34] || dbl[1][34] || dbl[2][34]) begin
      box_res = '0;
    end else begin
      box_res.hit   = 1'b1;
      box_res.axis  = best_axis;
      box_res.neg   = best_neg;
      box_res.depth = best[31:1];
    end
  end

  assign gc = {ground_level_r[31], ground_level_r} - {s1_center_r[1][31], s1_center_r[1]};

  // stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (ready2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && s1_valid_r) begin
      s2_kind_r    <= s1_kind_r;
      s2_box_r     <= box_res;
      s2_prod_r[0] <= prod[0];
      s2_prod_r[1] <= prod[1];
      s2_prod_r[2] <= prod[2];
      s2_gc_r      <= gc;
    end
  end

  // stage B: ground depth and result select
  assign gsum   = {1'b0, s2_prod_r[0]} + {1'b0, s2_prod_r[1]} + {1'b0, s2_prod_r[2]};
  assign gt     = gsum[SUM_W-1:FRAC_BITS+1];
  assign rem_nz = |gsum[FRAC_BITS:0];
  assign gv     = {{(VW-33){s2_gc_r[32]}}, s2_gc_r} + {2'b00, gt};

  always_comb begin
    ground_res = '0;
    if (!gv[VW-1] && ((gv != '0) || rem_nz)) begin
      ground_res.hit   = 1'b1;
      ground_res.axis  = bct_pkg::AXIS_Y;
      ground_res.neg   = 1'b0;
      ground_res.depth = (|gv[VW-2:31]) ? bct_pkg::DEPTH_MAX : gv[30:0];
    end
  end

  always_comb begin
    case (s2_kind_r)
      bct_pkg::KIND_BOX:    res_nxt = s2_box_r;
      bct_pkg::KIND_GROUND: res_nxt = ground_res;
      default:              res_nxt = '0;
    endcase
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ready3) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && s2_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.depth, out_res_r.neg, out_res_r.axis, out_res_r.hit};

`ifndef NO_ASSERTIONS
  a_miss_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.hit |-> out_tdata == '0)
    else $error("miss result carries nonzero fields");

  a_axis_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_tdata[2:1] != 2'd3)
    else $error("normal axis out of range");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !ready3 |=> s2_valid_r)
    else $error("stage 2 request dropped under stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s2_valid_r && !s1_valid_r)
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
